[rtl/core/cis_pkg.sv]
// ----------------------------------------------------------------------------
// cis_pkg: shared types and constants for the categorical index sampler
// Field widths, command codes, sequencer states and the weight write request.
// ----------------------------------------------------------------------------
package cis_pkg;

    localparam int unsigned INDEX_W     = 6;
    localparam int unsigned WEIGHT_IN_W = 16;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned COUNT_W     = 7;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_SCAN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic                   en;
        logic [INDEX_W-1:0]     index;
        logic [WEIGHT_IN_W-1:0] value;
    } t_wr_req;

endpackage

[rtl/core/cis_weight_mem.sv]
// ----------------------------------------------------------------------------
// cis_weight_mem: weight store
// Single-port-write, registered-read memory of category weights. Filters
// writes beyond the store and keeps the low WEIGHT_BITS bits of each weight.
// ----------------------------------------------------------------------------
module cis_weight_mem #(
    parameter int unsigned MAX_CATEGORIES = 64,
    parameter int unsigned WEIGHT_BITS    = 16,
    parameter int unsigned IDX_W          = $clog2(MAX_CATEGORIES)
) (
    input  logic                   i_clk,
    input  cis_pkg::t_wr_req       i_wr,
    input  logic                   i_rd_en,
    input  logic [IDX_W-1:0]       i_rd_addr,
    output logic [WEIGHT_BITS-1:0] o_rd_data
);

    logic [WEIGHT_BITS-1:0] mem [MAX_CATEGORIES];
    logic [WEIGHT_BITS-1:0] r_rd_data;

    logic [31:0]            w_index_ext;
    logic [31:0]            w_value_ext;
    logic                   w_in_range;

    assign w_index_ext = 32'(i_wr.index);
    assign w_value_ext = 32'(i_wr.value);
    assign w_in_range  = (w_index_ext < MAX_CATEGORIES);

    always_ff @(posedge i_clk) begin
        if (i_wr.en && w_in_range) begin
            mem[w_index_ext[IDX_W-1:0]] <= w_value_ext[WEIGHT_BITS-1:0];
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/categorical_index_sampler_core.sv]
// ----------------------------------------------------------------------------
// categorical_index_sampler_core: inverse-CDF sampler over stored weights
// Holds category weights and draws an index against a uniform fraction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per item.
//   A write item stores one weight and gives no result.
//   A sample item gives one chosen index on the output channel
//   (o_out_valid / i_out_stall). The configuration channel (i_cfg_valid /
//   o_cfg_ready) sets the number of categories in use; write it while idle.
// Sequence:
//   A sample sums the weights of the n categories in use through the memory's
//   one read port, multiplies the total by the fraction to form the target,
//   then scans the running sum of the weights until it reaches the target.
//   The input stalls while a sample runs.
// Stall:
//   A finished index waits in the output register; the next item is accepted
//   meanwhile. If a second sample finishes while the first index is still
//   stalled, the sequencer holds its result until the register frees up.
// Reset:
//   Synchronous, active low. The count returns to 1; the weight store is not
//   cleared, so write every entry in use before sampling.
// ----------------------------------------------------------------------------
module categorical_index_sampler_core #(
    parameter int unsigned MAX_CATEGORIES = 64,
    parameter int unsigned WEIGHT_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cis_pkg::COUNT_W-1:0]      i_cfg_data,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_command,
    input  logic [cis_pkg::INDEX_W-1:0]      i_weight_index,
    input  logic [cis_pkg::WEIGHT_IN_W-1:0]  i_weight_value,
    input  logic [cis_pkg::FRAC_W-1:0]       i_uniform_fraction,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [cis_pkg::INDEX_W-1:0]      o_chosen_index
);

    localparam int unsigned IDX_W = $clog2(MAX_CATEGORIES);
    localparam int unsigned SUM_W = WEIGHT_BITS + IDX_W;
    localparam int unsigned TGT_W = SUM_W + cis_pkg::FRAC_W;

    cis_pkg::t_state r_state, n_state;

    logic [cis_pkg::COUNT_W-1:0] r_count;
    logic [IDX_W-1:0]            r_last_addr;
    logic [IDX_W-1:0]            r_addr;
    logic                        r_issue_done;
    logic                        r_rd_pend;
    logic                        r_rd_last;
    logic [IDX_W-1:0]            r_rd_idx;
    logic [cis_pkg::FRAC_W-1:0]  r_frac;
    logic [SUM_W-1:0]            r_total;
    logic [SUM_W-1:0]            r_cum;
    logic [TGT_W-1:0]            r_target;
    logic [IDX_W-1:0]            r_found;
    logic                        r_out_valid;
    logic [cis_pkg::INDEX_W-1:0] r_out_index;

    logic                        w_in_accept;
    logic                        w_sample;
    logic                        w_in_stall;
    logic                        w_rd_en;
    logic                        w_out_free;
    logic                        w_load_out;
    logic                        w_hit;
    logic                        w_scan_end;
    logic [WEIGHT_BITS-1:0]      w_rd_data;
    logic [SUM_W-1:0]            w_cum_next;
    logic [TGT_W-1:0]            w_cum_shift;
    logic [TGT_W-1:0]            w_product;
    logic [31:0]                 w_cnt_ext;
    logic [31:0]                 w_cnt_eff;
    logic [31:0]                 w_last_ext;
    logic [IDX_W-1:0]            w_out_sel;
    logic [31:0]                 w_out_ext;
    cis_pkg::t_wr_req            w_wr;

    // ---- count in use: zero means one, saturate at the store depth ----
    always_comb begin
        w_cnt_ext = 32'(r_count);
        if (w_cnt_ext == 32'd0) begin
            w_cnt_eff = 32'd1;
        end else if (w_cnt_ext > MAX_CATEGORIES) begin
            w_cnt_eff = MAX_CATEGORIES;
        end else begin
            w_cnt_eff = w_cnt_ext;
        end
        w_last_ext = w_cnt_eff - 32'd1;
    end

    assign w_in_accept = i_in_valid && !w_in_stall;
    assign w_sample    = w_in_accept && (i_command == cis_pkg::CMD_SAMPLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_wr.en    = w_in_accept && (i_command == cis_pkg::CMD_WRITE);
    assign w_wr.index = i_weight_index;
    assign w_wr.value = i_weight_value;

    cis_weight_mem #(
        .MAX_CATEGORIES (MAX_CATEGORIES),
        .WEIGHT_BITS    (WEIGHT_BITS),
        .IDX_W          (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    // ---- scan datapath ----
    assign w_cum_next  = r_cum + SUM_W'(w_rd_data);
    assign w_cum_shift = {w_cum_next, {cis_pkg::FRAC_W{1'b0}}};
    assign w_hit       = (w_cum_shift >= r_target);
    assign w_scan_end  = r_rd_pend && (w_hit || r_rd_last);
    assign w_product   = TGT_W'(r_frac) * TGT_W'(r_total);

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            cis_pkg::ST_IDLE: begin
                if (w_sample) n_state = cis_pkg::ST_SUM;
            end
            cis_pkg::ST_SUM: begin
                if (r_rd_pend && r_rd_last) n_state = cis_pkg::ST_MUL;
            end
            cis_pkg::ST_MUL: begin
                n_state = cis_pkg::ST_SCAN;
            end
            cis_pkg::ST_SCAN: begin
                if (w_scan_end) n_state = w_out_free ? cis_pkg::ST_IDLE : cis_pkg::ST_HOLD;
            end
            cis_pkg::ST_HOLD: begin
                if (w_out_free) n_state = cis_pkg::ST_IDLE;
            end
            default: n_state = cis_pkg::ST_IDLE;
        endcase
    end

    // ---- state outputs ----
    always_comb begin
        w_in_stall = 1'b1;
        w_rd_en    = 1'b0;
        w_load_out = 1'b0;
        w_out_sel  = r_rd_idx;
        case (r_state)
            cis_pkg::ST_IDLE: begin
                w_in_stall = 1'b0;
            end
            cis_pkg::ST_SUM: begin
                w_rd_en = !r_issue_done;
            end
            cis_pkg::ST_MUL: begin
                w_rd_en = 1'b0;
            end
            cis_pkg::ST_SCAN: begin
                w_rd_en    = !r_issue_done && !w_scan_end;
                w_load_out = w_scan_end && w_out_free;
            end
            cis_pkg::ST_HOLD: begin
                w_load_out = w_out_free;
                w_out_sel  = r_found;
            end
            default: begin
                w_in_stall = 1'b1;
            end
        endcase
    end

    assign w_out_ext = 32'(w_out_sel);

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cis_pkg::ST_IDLE;
            r_count      <= cis_pkg::COUNT_RESET;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_rd_last    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end

            // advance the read pointer; rewind it when a pass starts
            r_rd_pend <= w_rd_en;
            r_rd_last <= (r_addr == r_last_addr);
            if (w_sample || r_state == cis_pkg::ST_MUL) begin
                r_addr       <= '0;
                r_issue_done <= 1'b0;
            end else if (w_rd_en) begin
                if (r_addr == r_last_addr) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (w_sample) begin
            r_frac      <= i_uniform_fraction;
            r_last_addr <= w_last_ext[IDX_W-1:0];
            r_total     <= '0;
        end
        if (r_state == cis_pkg::ST_SUM && r_rd_pend) begin
            r_total <= r_total + SUM_W'(w_rd_data);
        end
        if (r_state == cis_pkg::ST_MUL) begin
            r_target <= w_product;
            r_cum    <= '0;
        end
        if (r_state == cis_pkg::ST_SCAN && r_rd_pend) begin
            r_cum <= w_cum_next;
            if (w_scan_end) begin
                r_found <= r_rd_idx;
            end
        end
        if (w_load_out) begin
            r_out_index <= w_out_ext[cis_pkg::INDEX_W-1:0];
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = w_in_stall;
    assign o_out_valid    = r_out_valid;
    assign o_chosen_index = r_out_index;

endmodule

[sim/tb_categorical_index_sampler_core.sv]
// ----------------------------------------------------------------------------
// tb_categorical_index_sampler_core: self-checking bench for the sampler core
// Loads every weight entry, runs directed corner items (zero total, fraction
// extremes, count zero and count saturation), then random write/sample mixes
// under several gap and stall mixes plus one long output hold-off. A built-in
// inverse-CDF predictor scores every chosen index in order.
// ----------------------------------------------------------------------------
module tb_categorical_index_sampler_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CATEGORIES   = 64;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned HOLD_CYCLES  = 1500;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned REPORT_MAX   = 10;

    typedef logic [cis_pkg::INDEX_W-1:0]     t_index;
    typedef logic [cis_pkg::WEIGHT_IN_W-1:0] t_weight;
    typedef logic [cis_pkg::FRAC_W-1:0]      t_frac;
    typedef logic [cis_pkg::COUNT_W-1:0]     t_count;

    typedef struct packed {
        logic                            command;
        logic [cis_pkg::INDEX_W-1:0]     index;
        logic [cis_pkg::WEIGHT_IN_W-1:0] value;
        logic [cis_pkg::FRAC_W-1:0]      fraction;
    } t_request;

    typedef enum logic [1:0] {
        GAPS_NONE,
        GAPS_SENDER,
        GAPS_RECEIVER,
        GAPS_BOTH
    } t_gap_mode;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [cis_pkg::COUNT_W-1:0]     i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            i_command = cis_pkg::CMD_WRITE;
    logic [cis_pkg::INDEX_W-1:0]     i_weight_index = '0;
    logic [cis_pkg::WEIGHT_IN_W-1:0] i_weight_value = '0;
    logic [cis_pkg::FRAC_W-1:0]      i_uniform_fraction = '0;
    logic                            i_out_stall = 1'b0;
    logic                            o_cfg_ready;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic [cis_pkg::INDEX_W-1:0]     o_chosen_index;

    // predictor state
    logic [cis_pkg::WEIGHT_IN_W-1:0] weight_q [CATEGORIES];
    logic [cis_pkg::COUNT_W-1:0]     category_count_q = cis_pkg::COUNT_RESET;
    logic [cis_pkg::INDEX_W-1:0]     expected_index_q [$];

    t_request                        request_q [$];
    t_request                        next_request;
    int unsigned                     items_in_flight = 0;
    int unsigned                     sender_gap_pct = 0;
    int unsigned                     receiver_stall_pct = 0;
    int unsigned                     mismatch_count = 0;
    int unsigned                     cycle_count = 0;
    int unsigned                     hold_left = 0;
    logic                            hold_arm = 1'b0;
    logic [cis_pkg::INDEX_W-1:0]     expected_index;

    categorical_index_sampler_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_weight_index     (i_weight_index),
        .i_weight_value     (i_weight_value),
        .i_uniform_fraction (i_uniform_fraction),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_chosen_index     (o_chosen_index)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // First index whose running sum, scaled by 2^16, reaches fraction * total.
    function automatic t_index draw_category(input t_frac fraction);
        int unsigned n;
        logic [63:0] total;
        logic [63:0] target;
        logic [63:0] running;
        n = category_count_q;
        if (n == 0) n = 1;
        if (n > CATEGORIES) n = CATEGORIES;
        total = '0;
        for (int unsigned i = 0; i < n; i++) total += 64'(weight_q[i]);
        target = 64'(fraction) * total;
        running = '0;
        for (int unsigned i = 0; i < n; i++) begin
            running += 64'(weight_q[i]);
            if ((running << cis_pkg::FRAC_W) >= target) return t_index'(i);
        end
        return t_index'(n - 1);
    endfunction

    // driver: one item per accepted handshake, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (i_command == cis_pkg::CMD_WRITE) begin
                    weight_q[i_weight_index] = i_weight_value;
                end else begin
                    expected_index_q.push_back(draw_category(i_uniform_fraction));
                end
                items_in_flight--;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
                    next_request = request_q.pop_front();
                    i_in_valid         <= 1'b1;
                    i_command          <= next_request.command;
                    i_weight_index     <= next_request.index;
                    i_weight_value     <= next_request.value;
                    i_uniform_fraction <= next_request.fraction;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off, counted down on its own
    always @(posedge i_clk) begin
        if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: score each accepted index, then pick the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_index_q.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("unexpected chosen_index %0d with nothing pending",
                                 o_chosen_index);
                    mismatch_count++;
                end else begin
                    expected_index = expected_index_q.pop_front();
                    if (o_chosen_index !== expected_index) begin
                        if (mismatch_count < REPORT_MAX)
                            $display("chosen_index mismatch: expected %0d, got %0d",
                                     expected_index, o_chosen_index);
                        mismatch_count++;
                    end
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_request(input t_request r);
        request_q.push_back(r);
        items_in_flight++;
    endtask

    task automatic queue_write(input t_index index, input t_weight value);
        t_request r;
        r.command  = cis_pkg::CMD_WRITE;
        r.index    = index;
        r.value    = value;
        r.fraction = t_frac'($urandom);
        push_request(r);
    endtask

    task automatic queue_sample(input t_frac fraction);
        t_request r;
        r.command  = cis_pkg::CMD_SAMPLE;
        r.index    = t_index'($urandom);
        r.value    = t_weight'($urandom);
        r.fraction = fraction;
        push_request(r);
    endtask

    task automatic wait_quiet();
        while (items_in_flight != 0 || expected_index_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write the count only once the block has drained
    task automatic set_count(input t_count value);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        category_count_q = value;
    endtask

    task automatic set_gaps(input t_gap_mode mode);
        sender_gap_pct     = (mode == GAPS_SENDER)   ? 49 : (mode == GAPS_BOTH) ? 29 : 0;
        receiver_stall_pct = (mode == GAPS_RECEIVER) ? 49 : (mode == GAPS_BOTH) ? 29 : 0;
    endtask

    // writes mostly land on entries in use so they move the distribution
    task automatic queue_random(input int unsigned n_items, input int unsigned sample_pct);
        int unsigned n_used;
        t_request r;
        n_used = category_count_q;
        if (n_used == 0) n_used = 1;
        if (n_used > CATEGORIES) n_used = CATEGORIES;
        for (int unsigned k = 0; k < n_items; k++) begin
            if (n_used <= 8 && $urandom_range(0, 39) == 0) begin
                // zero every weight in use, then draw
                for (int unsigned j = 0; j < n_used; j++) queue_write(t_index'(j), '0);
                queue_sample(t_frac'($urandom));
            end
            r.command = ($urandom_range(0, 99) < sample_pct) ? cis_pkg::CMD_SAMPLE
                                                             : cis_pkg::CMD_WRITE;
            if ($urandom_range(0, 3) != 0)
                r.index = t_index'($urandom_range(0, n_used - 1));
            else
                r.index = t_index'($urandom);
            case ($urandom_range(0, 5))
                0:       r.value = '0;
                1:       r.value = '1;
                2:       r.value = t_weight'($urandom_range(0, 15));
                default: r.value = t_weight'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       r.fraction = '0;
                1:       r.fraction = '1;
                default: r.fraction = t_frac'($urandom);
            endcase
            push_request(r);
        end
    endtask

    initial begin
        for (int i = 0; i < CATEGORIES; i++) weight_q[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_gaps(GAPS_NONE);

        // load every entry before anything reads it
        for (int unsigned j = 0; j < CATEGORIES; j++) queue_write(t_index'(j), t_weight'($urandom));

        // single category, zero and full weight
        set_count(7'd1);
        queue_write('0, '0);
        queue_sample('0);
        queue_sample('1);
        queue_write('0, '1);
        queue_sample('1);
        queue_sample('0);

        // full range of categories
        set_count(7'd64);
        queue_write(6'd63, '1);
        queue_write('0, '0);
        queue_sample('0);
        queue_sample('1);
        queue_sample(16'h8000);

        // count of zero acts as one
        set_count(7'd0);
        queue_sample(16'd40000);

        // count above the store saturates
        set_count(7'd127);
        queue_sample('1);
        queue_sample(16'd1);

        // zero total, then a single unit of weight on the last entry
        set_count(7'd2);
        queue_write('0, '0);
        queue_write(6'd1, '0);
        queue_sample(16'd12345);
        queue_write(6'd1, 16'd1);
        queue_sample('0);
        queue_sample('1);

        set_count(7'd64);
        queue_random(60, 60);

        set_count(7'd5);
        set_gaps(GAPS_SENDER);
        queue_random(120, 55);

        set_count(7'd17);
        set_gaps(GAPS_RECEIVER);
        queue_random(120, 55);

        set_count(7'd2);
        set_gaps(GAPS_BOTH);
        queue_random(120, 55);

        set_count(7'd1);
        set_gaps(GAPS_NONE);
        queue_random(50, 55);

        set_count(t_count'($urandom_range(1, 64)));
        set_gaps(GAPS_BOTH);
        queue_random(100, 55);

        // hold the output long enough for the block to back up its input
        set_count(7'd8);
        set_gaps(GAPS_NONE);
        @(posedge i_clk);
        hold_arm <= 1'b1;
        @(posedge i_clk);
        hold_arm <= 1'b0;
        queue_random(40, 90);

        set_count(7'd3);
        queue_random(40, 55);

        wait_quiet();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/cis_pkg.sv
rtl/core/cis_weight_mem.sv
rtl/core/categorical_index_sampler_core.sv
sim/tb_categorical_index_sampler_core.sv
